@@ rtl/bbsf_pkg.sv @@
// Shared types and constants for the bounded byte stream FIFO.
package bbsf_pkg;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 136;
    localparam int CFG_W     = 11;
    localparam int CNT_W     = 11;
    localparam int TOTAL_W   = 48;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = 11'd1024;

    // Result beat bit positions on m_tdata
    localparam int M_ACCEPTED_BIT = 0;
    localparam int M_POPPED_LSB   = 10;
    localparam int M_FILL_LSB     = 21;
    localparam int M_WRITTEN_LSB  = 32;
    localparam int M_READ_LSB     = 80;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_PEEK  = 2'd1,
        KIND_POP   = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data_byte;
        logic [9:0]       offset;
        logic [CNT_W-1:0] count;
    } op_t;

    typedef struct packed {
        logic               accepted;
        logic               read_valid;
        logic [CNT_W-1:0]   popped;
        logic [CNT_W-1:0]   fill_level;
        logic [TOTAL_W-1:0] written_total;
        logic [TOTAL_W-1:0] read_total;
        logic               end_seen;
        logic               at_eof;
    } status_t;

endpackage

@@ rtl/bounded_byte_stream_fifo_core.sv @@
// An accepted input beat is registered in stage s1, then its result beat in the
// result stage behind m_tvalid. One operation per cycle sustained while m_tready
// is high; the state update is combinational and the byte RAM read is pipelined into the result register.
// Reset: synchronous aresetn clears the head pointer, fill, totals, ended flag and the
// pipeline valids, and sets capacity to 1024; byte RAM contents are not cleared.
// Top level of the bounded byte stream FIFO.
module bounded_byte_stream_fifo_core #(
    parameter int DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: capacity write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bbsf_pkg::CFG_W-1:0]     cfg_data,
    // Operation input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] data_byte, [17:8] offset, [28:18] count, [31:29] zero
    input  logic [bbsf_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [bbsf_pkg::S_TUSER_W-1:0] s_tuser,
    // Result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] accepted, [8:1] read_byte, [9] read_valid, [20:10] popped,
    // [31:21] fill_level, [79:32] written_total, [127:80] read_total,
    // [128] end_seen, [129] at_eof, [135:130] zero
    output logic [bbsf_pkg::M_TDATA_W-1:0] m_tdata
);
    import bbsf_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [CFG_W-1:0] capacity_reg;
    logic             s1_valid_reg, s1_valid_next;
    op_t              s1_op_reg;
    logic             m_valid_reg, m_valid_next;
    status_t          status_reg;

    status_t          status;
    logic             s_beat;
    logic             advance;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;
    logic [7:0]       read_byte;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
        end else if (cfg_valid) begin
            capacity_reg <= cfg_data;
        end
    end

    // Advance the operation into the result stage when that stage is free or draining.
    always_comb begin
        advance       = s1_valid_reg && (!m_valid_reg || m_tready);
        s_tready      = !s1_valid_reg || !m_valid_reg || m_tready;
        s_beat        = s_tvalid && s_tready;
        s1_valid_next = s_beat ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        m_valid_next  = advance ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            s1_op_reg.kind      <= kind_t'(s_tuser);
            s1_op_reg.data_byte <= s_tdata[7:0];
            s1_op_reg.offset    <= s_tdata[17:8];
            s1_op_reg.count     <= s_tdata[28:18];
        end
        if (advance) begin
            status_reg <= status;
        end
    end

    bbsf_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (s1_op_reg),
        .op_valid  (advance),
        .capacity  (capacity_reg),
        .status    (status),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr)
    );

    // Read data register only moves on advance, so it holds while the result stalls.
    bbsf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (advance),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign read_byte = status_reg.read_valid ? ram_rdata : 8'd0;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0,
                        status_reg.at_eof,
                        status_reg.end_seen,
                        status_reg.read_total,
                        status_reg.written_total,
                        status_reg.fill_level,
                        status_reg.popped,
                        status_reg.read_valid,
                        read_byte,
                        status_reg.accepted};

endmodule

@@ rtl/bbsf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bbsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bbsf_core.sv @@
// FIFO state: head pointer, fill, totals, ended flag and per-operation update.
module bbsf_core #(
    parameter int DEPTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bbsf_pkg::op_t                op,
    input  logic                         op_valid,
    input  logic [bbsf_pkg::CFG_W-1:0]   capacity,
    output bbsf_pkg::status_t            status,
    output logic                         ram_we,
    output logic [$clog2(DEPTH)-1:0]     ram_waddr,
    output logic [7:0]                   ram_wdata,
    output logic [$clog2(DEPTH)-1:0]     ram_raddr
);
    import bbsf_pkg::*;

    localparam int AW        = $clog2(DEPTH);
    localparam int SW        = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam int CAP_LIMIT = (DEPTH > 2047) ? 2047 : DEPTH;
    localparam logic [CNT_W-1:0] DEPTH_CAP = CNT_W'(CAP_LIMIT);
    localparam logic [SW-1:0]    DEPTH_W   = SW'(DEPTH);

    logic [AW-1:0]      head_reg,    head_next;
    logic [CNT_W-1:0]   fill_reg,    fill_next;
    logic [TOTAL_W-1:0] written_reg, written_next;
    logic [TOTAL_W-1:0] read_reg,    read_next;
    logic               ended_reg,   ended_next;

    logic [CNT_W-1:0] eff_cap;
    logic             do_write;
    logic             do_peek;
    logic [CNT_W-1:0] pop_n;

    // Step stays within one lap of the ring wherever the result is used.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CNT_W-1:0] step);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(step);
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    always_comb begin
        eff_cap  = (capacity > DEPTH_CAP) ? DEPTH_CAP : capacity;
        do_write = (op.kind == KIND_WRITE) && !ended_reg && (fill_reg < eff_cap);
        do_peek  = (op.kind == KIND_PEEK) && ({1'b0, op.offset} < fill_reg);
        pop_n    = '0;
        if (op.kind == KIND_POP) begin
            pop_n = (op.count < fill_reg) ? op.count : fill_reg;
        end

        head_next    = ring_add(head_reg, pop_n);
        fill_next    = fill_reg + CNT_W'(do_write) - pop_n;
        written_next = written_reg + TOTAL_W'(do_write);
        read_next    = read_reg + TOTAL_W'(pop_n);
        ended_next   = ended_reg || (op.kind == KIND_END);

        status.accepted      = do_write;
        status.read_valid    = do_peek;
        status.popped        = pop_n;
        status.fill_level    = fill_next;
        status.written_total = written_next;
        status.read_total    = read_next;
        status.end_seen      = ended_next;
        status.at_eof        = ended_next && (fill_next == '0);

        ram_we    = op_valid && do_write;
        ram_waddr = ring_add(head_reg, fill_reg);
        ram_wdata = op.data_byte;
        ram_raddr = ring_add(head_reg, CNT_W'(op.offset));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            fill_reg    <= '0;
            written_reg <= '0;
            read_reg    <= '0;
            ended_reg   <= 1'b0;
        end else if (op_valid) begin
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            written_reg <= written_next;
            read_reg    <= read_next;
            ended_reg   <= ended_next;
        end
    end

endmodule

@@ rtl/bbsf_checker.sv @@
// Port-level checker for the bounded byte stream FIFO, bound to the top level.
module bbsf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bbsf_pkg::M_TDATA_W-1:0] m_tdata
);
    import bbsf_pkg::*;

    logic [TOTAL_W-1:0] last_written_reg;
    logic [TOTAL_W-1:0] last_read_reg;
    logic [CNT_W-1:0]   last_fill_reg;

    logic               m_beat;
    logic               r_accepted;
    logic [CNT_W-1:0]   r_popped;
    logic [CNT_W-1:0]   r_fill;
    logic [TOTAL_W-1:0] r_written;
    logic [TOTAL_W-1:0] r_read;

    assign m_beat     = m_tvalid && m_tready;
    assign r_accepted = m_tdata[M_ACCEPTED_BIT];
    assign r_popped   = m_tdata[M_POPPED_LSB +: CNT_W];
    assign r_fill     = m_tdata[M_FILL_LSB +: CNT_W];
    assign r_written  = m_tdata[M_WRITTEN_LSB +: TOTAL_W];
    assign r_read     = m_tdata[M_READ_LSB +: TOTAL_W];

    // Track the previous result beat; reset state matches the FIFO's own.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_written_reg <= '0;
            last_read_reg    <= '0;
            last_fill_reg    <= '0;
        end else if (m_beat) begin
            last_written_reg <= r_written;
            last_read_reg    <= r_read;
            last_fill_reg    <= r_fill;
        end
    end

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_written_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat |-> (r_written == last_written_reg + TOTAL_W'(r_accepted)))
        else $error("written total does not follow accepted writes");

    a_read_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat |-> (r_read == last_read_reg + TOTAL_W'(r_popped)))
        else $error("read total does not follow popped bytes");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat |-> (r_fill == last_fill_reg + CNT_W'(r_accepted) - r_popped))
        else $error("fill level does not follow writes and pops");

endmodule

bind bounded_byte_stream_fifo_core bbsf_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
